@@ rtl/dtg_pkg.sv @@
// Shared types and constants of the grouped decimal text block.
package dtg_pkg;

  localparam int unsigned ValueWidth = 64;
  localparam int unsigned CharWidth  = 8;

  localparam logic [CharWidth-1:0] CH_ZERO  = 8'h30;
  localparam logic [CharWidth-1:0] CH_COMMA = 8'h2C;
  localparam logic [CharWidth-1:0] CH_MINUS = 8'h2D;

  localparam logic [1:0] GROUP_LAST = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic       done;
    logic       neg;
    logic [1:0] mod3;
  } conv_stat_t;

endpackage

@@ rtl/dtg_in_if.sv @@
// Input channel: one binary value and its signedness flag.
interface dtg_in_if;
  logic                               valid;
  logic                               ready;
  logic [dtg_pkg::ValueWidth-1:0]     value;
  logic                               is_signed;

  modport source (output valid, output value, output is_signed, input ready);
  modport sink   (input valid, input value, input is_signed, output ready);
endinterface

@@ rtl/dtg_out_if.sv @@
// Output channel: one ASCII character and its last flag.
interface dtg_out_if;
  logic                               valid;
  logic                               ready;
  logic [dtg_pkg::CharWidth-1:0]      character;
  logic                               last;

  modport source (output valid, output character, output last, input ready);
  modport sink   (input valid, input character, input last, output ready);
endinterface

@@ rtl/dtg_bcd_conv.sv @@
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
module dtg_bcd_conv #(
  parameter int unsigned VALUE_BITS = 64,
  parameter int unsigned DIGITS     = 20,
  parameter int unsigned PW         = 5
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [dtg_pkg::ValueWidth-1:0]    value_i,
  input  logic                              is_signed_i,
  output logic [DIGITS-1:0][3:0]            digits_o,
  output logic [PW-1:0]                     top_o,
  output dtg_pkg::conv_stat_t               stat_o
);

  localparam int unsigned CW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

  logic [VALUE_BITS-1:0]   bin_q, bin_d;
  logic [DIGITS-1:0][3:0]  bcd_q, bcd_d;
  logic [DIGITS-1:0][3:0]  adj;
  logic [DIGITS*4-1:0]     adj_flat;
  logic [PW-1:0]           pos_q, pos_d;
  logic [1:0]              mod_q, mod_d;
  logic                    any_q, any_d;
  logic                    neg_q, neg_d;
  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic [VALUE_BITS-1:0]   raw;
  logic [PW:0]             nxt_idx;
  logic                    grows;

  assign raw = value_i[VALUE_BITS-1:0];

  always_comb begin
    for (int j = 0; j < DIGITS; j++) begin
      adj[j] = (bcd_q[j] >= 4'd5) ? bcd_q[j] + 4'd3 : bcd_q[j];
    end
  end

  assign adj_flat = adj;

  // The value at most doubles per step, so the digit count grows by one at most.
  assign nxt_idx = any_q ? ({1'b0, pos_q} + {{PW{1'b0}}, 1'b1}) : '0;

  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    pos_d  = pos_q;
    mod_d  = mod_q;
    any_d  = any_q;
    neg_d  = neg_q;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    grows  = 1'b0;
    if (start_i) begin
      neg_d  = is_signed_i & raw[VALUE_BITS-1];
      bin_d  = neg_d ? (~raw + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : raw;
      bcd_d  = '0;
      pos_d  = '0;
      mod_d  = '0;
      any_d  = 1'b0;
      busy_d = 1'b1;
      cnt_d  = CW'(VALUE_BITS - 1);
    end else if (busy_q) begin
      bcd_d = {adj_flat[DIGITS*4-2:0], bin_q[VALUE_BITS-1]};
      bin_d = {bin_q[VALUE_BITS-2:0], 1'b0};
      grows = (nxt_idx < (PW+1)'(DIGITS)) && (bcd_d[nxt_idx[PW-1:0]] != 4'd0);
      if (grows) begin
        pos_d = nxt_idx[PW-1:0];
        any_d = 1'b1;
        mod_d = !any_q ? 2'd0 : ((mod_q == dtg_pkg::GROUP_LAST) ? 2'd0 : mod_q + 2'd1);
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      any_q  <= 1'b0;
      pos_q  <= '0;
      mod_q  <= '0;
      neg_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      any_q  <= any_d;
      pos_q  <= pos_d;
      mod_q  <= mod_d;
      neg_q  <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign digits_o    = bcd_q;
  assign top_o       = pos_q;
  assign stat_o.done = done_q;
  assign stat_o.neg  = neg_q;
  assign stat_o.mod3 = mod_q;

endmodule

@@ rtl/decimal_text_with_grouping.sv @@
// Top level: 64-bit binary value to ASCII decimal text with comma grouping.
// An accepted value is converted one bit per cycle, then the registered done flag
// of the converter hands the digits to the character sequencer.
// Characters leave one per cycle while the sink is ready, at most 26 of them.
// The next value is taken once the last character sits in the output register.
// Reset clears all control state; the data registers are not reset.
module decimal_text_with_grouping #(
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  dtg_in_if.sink         in_i,
  dtg_out_if.source      out_o
);

  localparam int unsigned DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int unsigned PW     = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  dtg_pkg::state_e                 state_q, state_d;
  dtg_pkg::conv_stat_t             stat;
  logic [DIGITS-1:0][3:0]          digits;
  logic [PW-1:0]                   top;

  logic                            oval_q, oval_d;
  logic [dtg_pkg::CharWidth-1:0]   ochar_q, ochar_d;
  logic                            olast_q, olast_d;
  logic [PW-1:0]                   pos_q, pos_d;
  logic [1:0]                      mod_q, mod_d;
  logic                            negp_q, negp_d;
  logic                            commap_q, commap_d;
  logic                            in_xfer;
  logic                            emit_go;
  logic                            last_emit;

  assign in_i.ready = (state_q == dtg_pkg::ST_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;

  dtg_bcd_conv #(
    .VALUE_BITS (VALUE_BITS),
    .DIGITS     (DIGITS),
    .PW         (PW)
  ) u_conv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_xfer),
    .value_i     (in_i.value),
    .is_signed_i (in_i.is_signed),
    .digits_o    (digits),
    .top_o       (top),
    .stat_o      (stat)
  );

  assign emit_go   = (state_q == dtg_pkg::ST_EMIT) && (!oval_q || out_o.ready);
  assign last_emit = emit_go && !negp_q && !commap_q && (pos_q == '0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dtg_pkg::ST_IDLE: if (in_xfer)   state_d = dtg_pkg::ST_CONV;
      dtg_pkg::ST_CONV: if (stat.done) state_d = dtg_pkg::ST_EMIT;
      dtg_pkg::ST_EMIT: if (last_emit) state_d = dtg_pkg::ST_IDLE;
      default:                         state_d = dtg_pkg::ST_IDLE;
    endcase
  end

  // Character order: minus sign, then digits from the top, with a comma
  // pending after each digit whose position is a nonzero multiple of three.
  always_comb begin
    oval_d   = oval_q && !out_o.ready;
    ochar_d  = ochar_q;
    olast_d  = olast_q;
    pos_d    = pos_q;
    mod_d    = mod_q;
    negp_d   = negp_q;
    commap_d = commap_q;
    if ((state_q == dtg_pkg::ST_CONV) && stat.done) begin
      pos_d    = top;
      mod_d    = stat.mod3;
      negp_d   = stat.neg;
      commap_d = 1'b0;
    end
    if (emit_go) begin
      oval_d  = 1'b1;
      olast_d = 1'b0;
      if (negp_q) begin
        ochar_d = dtg_pkg::CH_MINUS;
        negp_d  = 1'b0;
      end else if (commap_q) begin
        ochar_d  = dtg_pkg::CH_COMMA;
        commap_d = 1'b0;
      end else begin
        ochar_d  = dtg_pkg::CH_ZERO + {4'd0, digits[pos_q]};
        olast_d  = (pos_q == '0);
        commap_d = (pos_q != '0) && (mod_q == 2'd0);
        if (pos_q != '0) begin
          pos_d = pos_q - PW'(1);
        end
        mod_d = (mod_q == 2'd0) ? dtg_pkg::GROUP_LAST : mod_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= dtg_pkg::ST_IDLE;
      oval_q   <= 1'b0;
      pos_q    <= '0;
      mod_q    <= '0;
      negp_q   <= 1'b0;
      commap_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      oval_q   <= oval_d;
      pos_q    <= pos_d;
      mod_q    <= mod_d;
      negp_q   <= negp_d;
      commap_q <= commap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ochar_q <= ochar_d;
    olast_q <= olast_d;
  end

  assign out_o.valid     = oval_q;
  assign out_o.character = ochar_q;
  assign out_o.last      = olast_q;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=>
      (out_o.valid && $stable(out_o.character) && $stable(out_o.last)))
    else $error("waiting character changed before its transfer");

  a_accept_starts_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == dtg_pkg::ST_CONV))
    else $error("accepted value did not start conversion");

  a_comma_after_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commap_q |-> ((state_q == dtg_pkg::ST_EMIT) && !negp_q))
    else $error("comma pending outside emission or before the sign");

  a_mod_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dtg_pkg::ST_EMIT) |-> (mod_q != 2'd3))
    else $error("group position out of range");

endmodule

@@ tb/sv/decimal_text_with_grouping_test.sv @@
// Self-checking testbench of the grouped decimal text block.
module decimal_text_with_grouping_test;

  localparam logic MODE_UNSIGNED = 1'b0;
  localparam logic MODE_SIGNED   = 1'b1;
  localparam int   HoldCycles    = 400;

  typedef struct packed {
    logic [dtg_pkg::CharWidth-1:0] character;
    logic                          last;
  } text_char_t;

  logic clk_i;
  logic rst_ni;

  dtg_in_if  in_ch ();
  dtg_out_if out_ch ();

  decimal_text_with_grouping DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  text_char_t expected_text [$];
  int         mismatches = 0;
  logic       steady_flow;
  logic       hold_req;
  logic       hold_seen = 1'b0;
  int         hold_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Expected characters of one value: optional minus, digits, and a comma in
  // front of every full group of three digits but never in front of the first.
  function automatic void predict_text(input logic [dtg_pkg::ValueWidth-1:0] raw,
                                       input logic mode);
    logic                           negative;
    logic [dtg_pkg::ValueWidth-1:0] mag;
    logic [3:0]                     digits [20];
    int                             ndig;
    logic [dtg_pkg::CharWidth-1:0]  txt [$];
    text_char_t                     entry;
    negative  = (mode == MODE_SIGNED) && raw[dtg_pkg::ValueWidth-1];
    mag       = negative ? (~raw + 1'b1) : raw;
    ndig      = 0;
    digits[0] = 4'd0;
    while (mag != 0) begin
      digits[ndig] = 4'(mag % 10);
      mag = mag / 10;
      ndig++;
    end
    if (ndig == 0) ndig = 1;
    if (negative) txt.push_back(dtg_pkg::CH_MINUS);
    for (int i = ndig - 1; i >= 0; i--) begin
      txt.push_back(dtg_pkg::CH_ZERO + {4'd0, digits[i]});
      if (i > 0 && i % 3 == 0) txt.push_back(dtg_pkg::CH_COMMA);
    end
    foreach (txt[k]) begin
      entry.character = txt[k];
      entry.last      = (k == txt.size() - 1);
      expected_text.push_back(entry);
    end
  endfunction

  // Called at a rising edge. Valid stays high after the transfer so that a
  // following call in the same step can present the next value directly.
  task automatic offer_value(input logic [dtg_pkg::ValueWidth-1:0] raw, input logic mode);
    while (!steady_flow && $urandom_range(99) < 9) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.value     <= raw;
    in_ch.is_signed <= mode;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predict_text(raw, mode);
  endtask

  task automatic release_input();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_text_drained();
    while (expected_text.size() != 0) @(posedge clk_i);
  endtask

  // Mix of magnitudes: small numbers near the comma thresholds, powers of ten
  // and their neighbors, random bit lengths and fully random words.
  function automatic logic [dtg_pkg::ValueWidth:0] random_operand();
    logic [dtg_pkg::ValueWidth-1:0] v;
    logic [dtg_pkg::ValueWidth-1:0] p;
    logic                           mode;
    int                             kind;
    kind = $urandom_range(9);
    mode = 1'($urandom_range(1));
    p    = 64'd1;
    case (kind)
      0: v = 64'($urandom_range(2000));
      1: v = {$urandom, $urandom};
      2: begin
        repeat ($urandom_range(19)) p = p * 10;
        v = p + $urandom_range(2) - 1;
      end
      default: v = {$urandom, $urandom} >> $urandom_range(63);
    endcase
    if (mode == MODE_SIGNED && $urandom_range(1)) v = ~v + 1'b1;
    return {mode, v};
  endfunction

  task automatic test_directed();
    offer_value(64'd0, MODE_UNSIGNED);
    offer_value(64'd0, MODE_SIGNED);
    offer_value(64'd7, MODE_UNSIGNED);
    offer_value(64'd999, MODE_UNSIGNED);
    offer_value(64'd1000, MODE_UNSIGNED);
    offer_value(-64'sd1, MODE_SIGNED);
    offer_value(-64'sd999, MODE_SIGNED);
    offer_value(-64'sd1000, MODE_SIGNED);
    // Negative values whose digit count is a multiple of three.
    offer_value(-64'sd123456, MODE_SIGNED);
    offer_value(-64'sd100, MODE_SIGNED);
    offer_value(64'd999999, MODE_UNSIGNED);
    offer_value(64'd1000000, MODE_SIGNED);
    offer_value(64'hFFFF_FFFF_FFFF_FFFF, MODE_UNSIGNED);
    offer_value(64'hFFFF_FFFF_FFFF_FFFF, MODE_SIGNED);
    offer_value(64'h8000_0000_0000_0000, MODE_SIGNED);
    offer_value(64'h8000_0000_0000_0000, MODE_UNSIGNED);
    offer_value(64'h7FFF_FFFF_FFFF_FFFF, MODE_SIGNED);
    offer_value(64'h7FFF_FFFF_FFFF_FFFF, MODE_UNSIGNED);
    offer_value(64'd10000000000000000000, MODE_UNSIGNED);
    offer_value(64'd9999999999999999999, MODE_UNSIGNED);
    offer_value(64'd1000000000000000000, MODE_SIGNED);
    offer_value(64'hAAAA_AAAA_5555_5555, MODE_UNSIGNED);
    offer_value(64'h5555_5555_AAAA_AAAA, MODE_SIGNED);
    release_input();
  endtask

  task automatic test_random_mix(input int count);
    logic [dtg_pkg::ValueWidth:0] op;
    repeat (count) begin
      op = random_operand();
      offer_value(op[dtg_pkg::ValueWidth-1:0], op[dtg_pkg::ValueWidth]);
    end
    release_input();
  endtask

  // The sink holds off while values keep coming, so the input stalls.
  task automatic test_output_hold();
    logic [dtg_pkg::ValueWidth:0] op;
    hold_req <= ~hold_req;
    repeat (8) begin
      op = random_operand();
      offer_value(op[dtg_pkg::ValueWidth-1:0], op[dtg_pkg::ValueWidth]);
    end
    release_input();
  endtask

  task automatic test_drain_pause();
    repeat (4) begin
      test_random_mix(10);
      wait_text_drained();
    end
  endtask

  task automatic test_steady_flow();
    steady_flow <= 1'b1;
    test_random_mix(60);
    steady_flow <= 1'b0;
  endtask

  // Sink side: random stalls unless steady flow is set, plus a long hold-off when requested.
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen    <= hold_req;
      hold_left    <= HoldCycles;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= steady_flow || ($urandom_range(99) >= 9);
    end
  end

  always @(posedge clk_i) begin
    text_char_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_text.size() == 0) begin
        $display("%0t: unexpected character %h last %b", $time, out_ch.character, out_ch.last);
        mismatches++;
      end else begin
        want = expected_text.pop_front();
        if (out_ch.character !== want.character) begin
          $display("%0t: character expected %h got %h", $time, want.character,
                   out_ch.character);
          mismatches++;
        end
        if (out_ch.last !== want.last) begin
          $display("%0t: last expected %b got %b", $time, want.last, out_ch.last);
          mismatches++;
        end
      end
    end
  end

  initial begin
    steady_flow      = 1'b0;
    hold_req         = 1'b0;
    rst_ni           = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.value      = '0;
    in_ch.is_signed  = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_mix(200);
    test_output_hold();
    test_drain_pause();
    test_steady_flow();
    test_random_mix(100);

    wait_text_drained();
    repeat (100) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
